>>> hdl/ezr_pkg.sv
// Shared widths, types and the quarter-wave sine table builder for the Euler-to-matrix block.
package ezr_pkg;

   // angle and fixed-point format
   localparam int ANGLE_BITS = 12;
   localparam int FRAC_BITS  = 16;

   // quarter-wave table geometry
   localparam int QSHIFT  = ANGLE_BITS - 2;
   localparam int QUARTER = 1 << QSHIFT;
   localparam int IDX_W   = QSHIFT + 1;

   // datapath widths
   localparam int MAG_W  = FRAC_BITS + 1;
   localparam int VAL_W  = FRAC_BITS + 2;
   localparam int OUT_W  = VAL_W;
   localparam int PROD_W = 2 * VAL_W - 1;
   localparam int WIDE_W = PROD_W + VAL_W;
   localparam int SUM_W  = WIDE_W + 1;

   // register stages from req beat to rsp register: fold, table, pairs, triples, round
   localparam int PIPE_STAGES = 5;

   // stream payload widths, padded to whole bytes
   localparam int REQ_W = ((3 * ANGLE_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((9 * OUT_W + 7) / 8) * 8;

   localparam real PI_VALUE   = 3.14159265358979323846;
   localparam real ANGLE_STEP = PI_VALUE / (2.0 ** (ANGLE_BITS - 1));
   localparam real FULL_SCALE = 2.0 ** FRAC_BITS;

   typedef logic [MAG_W-1:0] sine_rom_type [QUARTER+1];

   // table magnitude plus the sign that the quadrant gives
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
   } trig_ref_type;

   typedef struct packed {
      trig_ref_type s;
      trig_ref_type c;
   } sin_cos_type;

   // round(2^FRAC_BITS * sin(i * step)), ties away from zero (all entries are >= 0)
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      real          x;
      for (int i = 0; i <= QUARTER; i++) begin
         x      = $sin(ANGLE_STEP * real'(i)) * FULL_SCALE + 0.5;
         rom[i] = MAG_W'($rtoi(x));
      end
      return rom;
   endfunction

endpackage

>>> hdl/ezr_sine.sv
// Sine and cosine of one angle: quadrant fold, then a registered quarter-wave table read.
module ezr_sine (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [ezr_pkg::ANGLE_BITS-1:0]  angle,
   output ezr_pkg::sin_cos_type            trig
);
   import ezr_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [1:0]        quad_s;
   logic [1:0]        quad_c;
   logic [QSHIFT-1:0] rem;
   logic [IDX_W-1:0]  idx_s_in, idx_c_in;
   logic [IDX_W-1:0]  idx_s_ff, idx_c_ff;
   logic              neg_s_ff, neg_c_ff;
   sin_cos_type       trig_ff;

   // fold onto the first quadrant; cosine is the sine a quarter turn ahead
   always_comb begin
      quad_s   = angle[ANGLE_BITS-1 -: 2];
      quad_c   = quad_s + 2'd1;
      rem      = angle[QSHIFT-1:0];
      idx_s_in = quad_s[0] ? IDX_W'(QUARTER) - {1'b0, rem} : {1'b0, rem};
      idx_c_in = quad_c[0] ? IDX_W'(QUARTER) - {1'b0, rem} : {1'b0, rem};
   end

   // stage 1: table addresses and signs
   always_ff @(posedge clock) begin
      if (enable) begin
         idx_s_ff <= idx_s_in;
         idx_c_ff <= idx_c_in;
         neg_s_ff <= quad_s[1];
         neg_c_ff <= quad_c[1];
      end
   end

   // stage 2: table read
   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff.s.mag <= SINE_ROM[idx_s_ff];
         trig_ff.s.neg <= neg_s_ff;
         trig_ff.c.mag <= SINE_ROM[idx_c_ff];
         trig_ff.c.neg <= neg_c_ff;
      end
   end

   assign trig = trig_ff;

endmodule

>>> hdl/ezr_matrix.sv
// Matrix entries from six sines: two multiply stages, then rounding, clamp and packing.
module ezr_matrix (
   input  logic                       clock,
   input  logic                       enable,
   input  ezr_pkg::sin_cos_type       yaw_trig,
   input  ezr_pkg::sin_cos_type       pitch_trig,
   input  ezr_pkg::sin_cos_type       roll_trig,
   output logic [ezr_pkg::RSP_W-1:0]  rsp_data
);
   import ezr_pkg::*;

   localparam logic signed [SUM_W-1:0] RND2  = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] RND3  = SUM_W'(1) << (2 * FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) << FRAC_BITS;

   function automatic logic signed [VAL_W-1:0] to_signed(trig_ref_type t);
      logic signed [VAL_W-1:0] v;
      v = signed'({1'b0, t.mag});
      return t.neg ? -v : v;
   endfunction

   function automatic logic signed [PROD_W-1:0] mul1(logic signed [VAL_W-1:0] a,
                                                     logic signed [VAL_W-1:0] b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

   function automatic logic signed [WIDE_W-1:0] mul2(logic signed [PROD_W-1:0] a,
                                                     logic signed [VAL_W-1:0]  b);
      return WIDE_W'(a) * WIDE_W'(b);
   endfunction

   // round to FRAC_BITS fraction bits, ties up
   function automatic logic signed [SUM_W-1:0] round2(logic signed [PROD_W-1:0] x);
      return (SUM_W'(x) + RND2) >>> FRAC_BITS;
   endfunction

   // round (w + q * 2^F) / 2^(2F), ties up; q is subtracted when sub is set
   function automatic logic signed [SUM_W-1:0] round3(logic signed [WIDE_W-1:0] w,
                                                      logic signed [PROD_W-1:0] q,
                                                      logic                     sub);
      logic signed [SUM_W-1:0] qs;
      qs = SUM_W'(q) <<< FRAC_BITS;
      return (SUM_W'(w) + (sub ? -qs : qs) + RND3) >>> (2 * FRAC_BITS);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp(logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > ONE_S) r = ONE_S;
      if (v < -ONE_S) r = -ONE_S;
      return OUT_W'(r);
   endfunction

   logic signed [VAL_W-1:0]  sy, cy, sp, cp, sr, cr;

   // stage 3 registers
   logic signed [PROD_W-1:0] cycp_ff, sycp_ff, cpsr_ff, cpcr_ff, cysp_ff, sysp_ff;
   logic signed [PROD_W-1:0] sycr3_ff, sysr3_ff, cycr3_ff, cysr3_ff;
   logic signed [VAL_W-1:0]  sr3_ff, cr3_ff, nsp3_ff;

   // stage 4 registers
   logic signed [WIDE_W-1:0] w01_ff, w02_ff, w11_ff, w12_ff;
   logic signed [PROD_W-1:0] cycp4_ff, sycp4_ff, cpsr4_ff, cpcr4_ff;
   logic signed [PROD_W-1:0] sycr4_ff, sysr4_ff, cycr4_ff, cysr4_ff;
   logic signed [VAL_W-1:0]  nsp4_ff;

   logic signed [OUT_W-1:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic [RSP_W-1:0]         rsp_data_in, rsp_data_ff;

   // signed sines from table magnitudes
   always_comb begin
      sy = to_signed(yaw_trig.s);
      cy = to_signed(yaw_trig.c);
      sp = to_signed(pitch_trig.s);
      cp = to_signed(pitch_trig.c);
      sr = to_signed(roll_trig.s);
      cr = to_signed(roll_trig.c);
   end

   // stage 3: the pairwise products that the matrix needs
   always_ff @(posedge clock) begin
      if (enable) begin
         cycp_ff  <= mul1(cy, cp);
         sycp_ff  <= mul1(sy, cp);
         cpsr_ff  <= mul1(cp, sr);
         cpcr_ff  <= mul1(cp, cr);
         cysp_ff  <= mul1(cy, sp);
         sysp_ff  <= mul1(sy, sp);
         sycr3_ff <= mul1(sy, cr);
         sysr3_ff <= mul1(sy, sr);
         cycr3_ff <= mul1(cy, cr);
         cysr3_ff <= mul1(cy, sr);
         sr3_ff   <= sr;
         cr3_ff   <= cr;
         nsp3_ff  <= -sp;
      end
   end

   // stage 4: triple products, the rest carried along
   always_ff @(posedge clock) begin
      if (enable) begin
         w01_ff   <= mul2(cysp_ff, sr3_ff);
         w02_ff   <= mul2(cysp_ff, cr3_ff);
         w11_ff   <= mul2(sysp_ff, sr3_ff);
         w12_ff   <= mul2(sysp_ff, cr3_ff);
         cycp4_ff <= cycp_ff;
         sycp4_ff <= sycp_ff;
         cpsr4_ff <= cpsr_ff;
         cpcr4_ff <= cpcr_ff;
         sycr4_ff <= sycr3_ff;
         sysr4_ff <= sysr3_ff;
         cycr4_ff <= cycr3_ff;
         cysr4_ff <= cysr3_ff;
         nsp4_ff  <= nsp3_ff;
      end
   end

   // stage 5: sums, rounding and clamp
   always_comb begin
      m00 = clamp(round2(cycp4_ff));
      m01 = clamp(round3(w01_ff, sycr4_ff, 1'b1));
      m02 = clamp(round3(w02_ff, sysr4_ff, 1'b0));
      m10 = clamp(round2(sycp4_ff));
      m11 = clamp(round3(w11_ff, cycr4_ff, 1'b0));
      m12 = clamp(round3(w12_ff, cysr4_ff, 1'b1));
      m20 = clamp(SUM_W'(nsp4_ff));
      m21 = clamp(round2(cpsr4_ff));
      m22 = clamp(round2(cpcr4_ff));
      rsp_data_in = RSP_W'({m22, m21, m20, m12, m11, m10, m02, m01, m00});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

>>> hdl/euler_zyx_to_rotation_matrix.sv
// Throughput: one beat per cycle unless rsp stalls; stages are fold, sine table read,
// pair products, triple products, and round/clamp, each behind its own register.
// A stalled rsp side freezes every stage in place, so nothing is lost or repeated.
// Reset (synchronous, active high) clears only the stage valid bits.
module euler_zyx_to_rotation_matrix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // yaw_angle [11:0], pitch_angle [23:12], roll_angle [35:24], zero pad above
   input  logic [ezr_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 18 bits each, zero pad
   output logic [ezr_pkg::RSP_W-1:0]   rsp_tdata
);
   import ezr_pkg::*;

   logic                   enable;
   logic [PIPE_STAGES-1:0] vld_in, vld_ff;
   sin_cos_type            yaw_trig, pitch_trig, roll_trig;

   // whole pipeline advances unless the output beat is held
   assign enable     = !vld_ff[PIPE_STAGES-1] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = vld_ff[PIPE_STAGES-1];

   // valid bits travel with the data
   assign vld_in = {vld_ff[PIPE_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   ezr_sine u_yaw (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[ANGLE_BITS-1:0]),
      .trig   (yaw_trig)
   );

   ezr_sine u_pitch (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
      .trig   (pitch_trig)
   );

   ezr_sine u_roll (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
      .trig   (roll_trig)
   );

   ezr_matrix u_matrix (
      .clock      (clock),
      .enable     (enable),
      .yaw_trig   (yaw_trig),
      .pitch_trig (pitch_trig),
      .roll_trig  (roll_trig),
      .rsp_data   (rsp_tdata)
   );

endmodule

>>> dv/tb.sv
// Self-checking stream testbench for euler_zyx_to_rotation_matrix.
module tb;
   import ezr_pkg::*;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   // m00 in [0], then m01 .. m22, same order as rsp_tdata
   typedef logic [8:0][OUT_W-1:0] matrix_type;

   typedef struct {
      angle_type  yaw;
      angle_type  pitch;
      angle_type  roll;
      bit         typed;
      matrix_type mat;
   } angle_row_type;

   localparam int      PIPE_LAT     = PIPE_STAGES;
   localparam int      RANDOM_ITEMS = 850;
   localparam int      LONG_HOLD    = 300;
   localparam int      QUIET_LIMIT  = 2000;
   localparam int      MAX_REPORTS  = 40;
   localparam longint  UNIT         = longint'(1) << FRAC_BITS;
   localparam int      QTURN        = QUARTER;
   localparam int      HALF_TURN    = -2 * QUARTER;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   euler_zyx_to_rotation_matrix dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   longint        quarter_sines [QUARTER+1];
   matrix_type    expected_mats [$];
   angle_row_type angle_rows [$];
   string         entry_names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                      "m20", "m21", "m22"};

   int  err_count     = 0;
   int  sent_count    = 0;
   int  checked_count = 0;
   int  quiet_cycles  = 0;
   bit  tx_calm       = 1'b0;
   bit  rx_calm       = 1'b0;
   bit  long_hold_req = 1'b0;

   // (a*b) >> 62 on unsigned Q2.62 values
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // quarter-wave sine, rounded to FRAC_BITS, built with an integer Taylor series
   initial begin : build_sines
      logic [63:0] x, x2, sum, term;
      for (int i = 0; i <= QUARTER; i++) begin
         x = (HALF_PI_Q62 >> QSHIFT) * 64'(i)
             + (((HALF_PI_Q62 & 64'(QUARTER - 1)) * 64'(i)) >> QSHIFT);
         x2   = mul_q62(x, x);
         sum  = x;
         term = x;
         for (int k = 1; k < 40 && term != 0; k++) begin
            term = mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         quarter_sines[i] = longint'((sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
      end
   end

   // full-circle sine from the quarter table by quadrant symmetry
   function automatic longint sine_of(logic [ANGLE_BITS-1:0] a);
      logic [1:0]        quad;
      logic [QSHIFT-1:0] r;
      longint            v;
      quad = a[ANGLE_BITS-1 -: 2];
      r    = a[QSHIFT-1:0];
      v    = quad[0] ? quarter_sines[QUARTER - int'(r)] : quarter_sines[r];
      return quad[1] ? -v : v;
   endfunction

   // x carries 2F fraction bits; round half up to F
   function automatic longint round_pair(longint x);
      return (x + (UNIT >>> 1)) >>> FRAC_BITS;
   endfunction

   // (p*c + q*2^F) carries 3F fraction bits; round half up to F
   function automatic longint round_triple(longint p, longint c, longint q);
      return (p * c + (q <<< FRAC_BITS) + (longint'(1) <<< (2 * FRAC_BITS - 1)))
             >>> (2 * FRAC_BITS);
   endfunction

   // expected Rz(yaw)*Ry(pitch)*Rx(roll), clamped to +-1
   function automatic matrix_type rotation_matrix(angle_type yaw, angle_type pitch,
                                                  angle_type roll);
      longint     sy, cy, sp, cp, sr, cr, cysp, sysp;
      longint     raw [9];
      matrix_type m;
      sy   = sine_of(yaw);
      cy   = sine_of(ANGLE_BITS'(yaw + QTURN));
      sp   = sine_of(pitch);
      cp   = sine_of(ANGLE_BITS'(pitch + QTURN));
      sr   = sine_of(roll);
      cr   = sine_of(ANGLE_BITS'(roll + QTURN));
      cysp = cy * sp;
      sysp = sy * sp;
      raw[0] = round_pair(cy * cp);
      raw[1] = round_triple(cysp, sr, -(sy * cr));
      raw[2] = round_triple(cysp, cr, sy * sr);
      raw[3] = round_pair(sy * cp);
      raw[4] = round_triple(sysp, sr, cy * cr);
      raw[5] = round_triple(sysp, cr, -(cy * sr));
      raw[6] = -sp;
      raw[7] = round_pair(cp * sr);
      raw[8] = round_pair(cp * cr);
      for (int k = 0; k < 9; k++) begin
         if (raw[k] > UNIT) raw[k] = UNIT;
         if (raw[k] < -UNIT) raw[k] = -UNIT;
         m[k] = OUT_W'(raw[k]);
      end
      return m;
   endfunction

   function automatic matrix_type mat9(longint a0, longint a1, longint a2, longint a3,
                                       longint a4, longint a5, longint a6, longint a7,
                                       longint a8);
      matrix_type m;
      m = {OUT_W'(a8), OUT_W'(a7), OUT_W'(a6), OUT_W'(a5), OUT_W'(a4),
           OUT_W'(a3), OUT_W'(a2), OUT_W'(a1), OUT_W'(a0)};
      return m;
   endfunction

   task automatic add_row(int yaw, int pitch, int roll, bit typed = 1'b0,
                          matrix_type mat = '0);
      angle_row_type row;
      row.yaw    = angle_type'(yaw);
      row.pitch  = angle_type'(pitch);
      row.roll   = angle_type'(roll);
      row.typed  = typed;
      row.mat    = mat;
      angle_rows = {angle_rows, row};
   endtask

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      return ($urandom_range(0, 19) == 0) ? int'($urandom_range(20, 60))
                                          : int'($urandom_range(1, 3));
   endfunction

   function automatic angle_type rand_angle();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 8))
            0: return angle_type'(HALF_TURN);
            1: return angle_type'(-QTURN - 1);
            2: return angle_type'(-QTURN);
            3: return angle_type'(-1);
            4: return angle_type'(0);
            5: return angle_type'(1);
            6: return angle_type'(QTURN - 1);
            7: return angle_type'(QTURN);
            default: return angle_type'(-HALF_TURN - 1);
         endcase
      end
      return angle_type'($urandom_range(0, (1 << ANGLE_BITS) - 1));
   endfunction

   // one req beat; called at a falling edge, returns at the falling edge after acceptance
   task automatic send_triple(angle_type yaw, angle_type pitch, angle_type roll, bit typed,
                              matrix_type mat);
      matrix_type want;
      req_tdata  <= REQ_W'({roll, pitch, yaw});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      want          = typed ? mat : rotation_matrix(yaw, pitch, roll);
      expected_mats = {expected_mats, want};
      sent_count++;
      @(negedge clock);
   endtask

   task automatic idle_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (expected_mats.size() != 0) @(negedge clock);
   endtask

   // rsp side: random stalls, calm stretches and one long hold-off
   initial begin : rsp_stall
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            stall_left = gap_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare every rsp beat with the oldest expected matrix
   always @(posedge clock) begin
      matrix_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[9*OUT_W-1:0];
         if (expected_mats.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("%0t: rsp beat with nothing expected, data %h", $time, got);
         end else begin
            want = expected_mats.pop_front();
            checked_count++;
            for (int k = 0; k < 9; k++) begin
               if (got[k] !== want[k]) begin
                  err_count++;
                  if (err_count <= MAX_REPORTS)
                     $display("%0t: %s expected %0d actual %0d", $time, entry_names[k],
                              $signed(want[k]), $signed(got[k]));
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d matrices still due", $time,
                  quiet_cycles, expected_mats.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      angle_type y, p, r;
      int        n_directed;

      // zero angles, half turns and quarter turns read off directly
      add_row(0, 0, 0, 1'b1, mat9(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT));
      add_row(HALF_TURN, HALF_TURN, HALF_TURN, 1'b1, mat9(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT));
      add_row(HALF_TURN, 0, 0, 1'b1, mat9(-UNIT, 0, 0, 0, -UNIT, 0, 0, 0, UNIT));
      add_row(QTURN, 0, 0, 1'b1, mat9(0, -UNIT, 0, UNIT, 0, 0, 0, 0, UNIT));
      add_row(0, QTURN, 0, 1'b1, mat9(0, 0, UNIT, 0, UNIT, 0, -UNIT, 0, 0));
      add_row(0, 0, QTURN, 1'b1, mat9(UNIT, 0, 0, 0, 0, -UNIT, 0, UNIT, 0));
      // code extremes and small steps
      add_row(-HALF_TURN - 1, -HALF_TURN - 1, -HALF_TURN - 1);
      add_row(-1, -1, -1);
      add_row(1, 1, 1);
      add_row(-QTURN, -QTURN, -QTURN);
      add_row(QTURN / 2, QTURN / 2, QTURN / 2);
      add_row(-1, -HALF_TURN - 1, HALF_TURN);
      add_row(QTURN - 1, -QTURN + 1, 1);
      // pitch at a quarter turn with roll = yaw or -yaw: rounded sums can pass one and clamp
      add_row(100, QTURN, 100);
      add_row(341, QTURN, 341);
      add_row(QTURN / 2, QTURN, QTURN / 2);
      add_row(777, QTURN, 777);
      add_row(1500, QTURN, 1500);
      add_row(200, -QTURN, -200);
      n_directed = angle_rows.size();

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (angle_rows[i]) begin
         send_triple(angle_rows[i].yaw, angle_rows[i].pitch, angle_rows[i].roll,
                     angle_rows[i].typed, angle_rows[i].mat);
         if ($urandom_range(0, 3) == 0) idle_sender(gap_len());
      end
      idle_sender(1);
      wait_drained();

      // random triples
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) begin
            long_hold_req = 1'b1;
            tx_calm       = 1'b1;
         end
         if (n == 190) tx_calm = 1'b0;
         if (n == 550) begin
            tx_calm = 1'b1;
            rx_calm = 1'b1;
         end
         if (n == 650) begin
            tx_calm = 1'b0;
            rx_calm = 1'b0;
         end
         y = rand_angle();
         p = rand_angle();
         r = rand_angle();
         if ($urandom_range(0, 7) == 0) begin
            p = $urandom_range(0, 1) ? angle_type'(QTURN) : angle_type'(-QTURN);
            r = $urandom_range(0, 1) ? y : -y;
         end
         send_triple(y, p, r, 1'b0, '0);
         if (n == 400) begin
            // sender holds back until the pipeline has emptied
            idle_sender(1);
            wait_drained();
         end else if (!tx_calm && $urandom_range(0, 3) == 0) begin
            idle_sender(gap_len());
         end
      end
      idle_sender(1);

      while (expected_mats.size() != 0) @(posedge clock);
      repeat (4 * PIPE_LAT) @(posedge clock);

      $display("Sent %0d angle triples (%0d directed), compared %0d matrices, %0d errors.",
               sent_count, n_directed, checked_count, err_count);
      $display("Covered code extremes, quarter and half turns, clamped sums, %0d-cycle hold.",
               LONG_HOLD);
      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> euler_zyx_to_rotation_matrix.f
hdl/ezr_pkg.sv
hdl/ezr_sine.sv
hdl/ezr_matrix.sv
hdl/euler_zyx_to_rotation_matrix.sv
dv/tb.sv
